FILE: rtl/tds_pkg.sv
`default_nettype none

package tds_pkg;

  // table limits
  localparam int TASK_SLOTS_DEF = 8;
  localparam int ID_LIMIT = 8;
  localparam int ID_W = 3;
  localparam int IDC_W = ID_W + 1;
  localparam int TIME_W = 32;

  // command codes
  localparam logic [2:0] CMD_CLEAR = 3'd0;
  localparam logic [2:0] CMD_ADD = 3'd1;
  localparam logic [2:0] CMD_ENABLE = 3'd2;
  localparam logic [2:0] CMD_DISABLE = 3'd3;
  localparam logic [2:0] CMD_TICK = 3'd4;
  localparam logic [2:0] CMD_QUERY = 3'd5;

  // result status codes
  localparam logic [2:0] ST_ADDED = 3'd0;
  localparam logic [2:0] ST_FULL = 3'd1;
  localparam logic [2:0] ST_DUE = 3'd2;
  localparam logic [2:0] ST_NONE = 3'd3;
  localparam logic [2:0] ST_STATS = 3'd4;

  // input beat
  typedef struct packed {
    logic [2:0]        command;
    logic [ID_W-1:0]   task_id;
    logic [TIME_W-1:0] period_len;
    logic [TIME_W-1:0] now_ms;
  } req_t;

  // result beat
  typedef struct packed {
    logic [2:0]        status;
    logic [ID_W-1:0]   task_id_res;
    logic [TIME_W-1:0] run_total;
    logic              enabled;
    logic              last;
  } rsp_t;

  // one task table entry
  typedef struct packed {
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] last_run;
    logic [TIME_W-1:0] run_total;
    logic              en;
  } entry_t;

  // memory access from the sequencer
  typedef struct packed {
    logic            rd_en;
    logic [ID_W-1:0] rd_addr;
    logic            wr_en;
    logic [ID_W-1:0] wr_addr;
    entry_t          wdata;
  } mem_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/periodic_task_due_scheduler.sv
// periodic task due scheduler
// request channel (req_valid, req_stall, req) carries one command per beat:
// clear, add task, enable, disable, tick with the current time, query stats.
// response channel (rsp_valid, rsp_stall, rsp) returns result beats; the last
// beat of a command has rsp.last set. clear, enable, disable and unused codes
// give no beat.
// task entries live in one synchronous memory with a registered read; the
// sequencer reads, modifies and writes back one entry per cycle unless stalled.
// a tick reads the first entry, then scans the table entry by entry, and
// its final beat is then pushed into the output register.
// one command is worked on at a time; req_stall is high until it is done.
// results go to an output register; while rsp_stall holds that register
// full, the scan pauses on the next due task and the sequencer waits.
// reset empties the table and drops any pending result; table contents are
// not cleared, since add writes an entry before it can be read.
`default_nettype none

module periodic_task_due_scheduler #(
  parameter int TASK_SLOTS = tds_pkg::TASK_SLOTS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire tds_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output tds_pkg::rsp_t      rsp
);

  localparam int CAP = (TASK_SLOTS < tds_pkg::ID_LIMIT) ? TASK_SLOTS : tds_pkg::ID_LIMIT;

  logic              push;
  logic              push_ok;
  tds_pkg::rsp_t     push_beat;
  tds_pkg::mem_cmd_t mem_cmd;
  tds_pkg::entry_t   rdata;

  // task table
  tds_mem #(
    .DEPTH(CAP)
  ) u_mem (
    .clk(clk),
    .mem_cmd(mem_cmd),
    .rdata(rdata)
  );

  // command sequencer
  tds_seq #(
    .TASK_SLOTS(TASK_SLOTS)
  ) u_seq (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .push(push),
    .push_ok(push_ok),
    .push_beat(push_beat),
    .mem_cmd(mem_cmd),
    .rdata(rdata)
  );

  // output register accepts a new beat when empty or being taken
  assign push_ok = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (push_ok) begin
      rsp_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (push && push_ok) begin
      rsp <= push_beat;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tds_mem.sv
`default_nettype none

module tds_mem #(
  parameter int DEPTH = tds_pkg::ID_LIMIT
) (
  input  wire logic              clk,
  input  wire tds_pkg::mem_cmd_t mem_cmd,
  output tds_pkg::entry_t        rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  tds_pkg::entry_t store [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_cmd.wr_en) begin
      store[mem_cmd.wr_addr[AW-1:0]] <= mem_cmd.wdata;
    end
    if (mem_cmd.rd_en) begin
      rdata <= store[mem_cmd.rd_addr[AW-1:0]];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tds_seq.sv
`default_nettype none

module tds_seq #(
  parameter int TASK_SLOTS = tds_pkg::TASK_SLOTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire tds_pkg::req_t     req,
  output logic                   push,
  input  wire logic              push_ok,
  output tds_pkg::rsp_t          push_beat,
  output tds_pkg::mem_cmd_t      mem_cmd,
  input  wire tds_pkg::entry_t   rdata
);

  localparam int CAP = (TASK_SLOTS < tds_pkg::ID_LIMIT) ? TASK_SLOTS : tds_pkg::ID_LIMIT;
  localparam int CW = $clog2(CAP + 1);
  localparam int AW = (CAP > 1) ? $clog2(CAP) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RMW,
    S_QRD,
    S_SCAN,
    S_RESP
  } state_t;

  state_t                       state;
  logic [CW-1:0]                task_count;
  logic [AW-1:0]                idx;
  logic                         have;
  tds_pkg::req_t                req_q;
  tds_pkg::rsp_t                res;

  logic                         full;
  logic                         in_range;
  logic                         due;
  logic                         advance;
  logic                         scan_end;
  logic [tds_pkg::TIME_W-1:0]   elapsed;

  function automatic tds_pkg::rsp_t make_beat(
    input logic [2:0]                 status,
    input logic [tds_pkg::ID_W-1:0]   id,
    input logic [tds_pkg::TIME_W-1:0] runs,
    input logic                       en,
    input logic                       last
  );
    tds_pkg::rsp_t b;
    b.status = status;
    b.task_id_res = id;
    b.run_total = runs;
    b.enabled = en;
    b.last = last;
    return b;
  endfunction

  // table status
  assign full = (task_count == CW'(CAP));
  assign in_range = ({1'b0, req.task_id} < tds_pkg::IDC_W'(task_count));
  assign req_stall = (state != S_IDLE);

  // due test on the entry last read from memory, wrap-safe difference
  assign elapsed = req_q.now_ms - rdata.last_run;
  assign due = rdata.en && (elapsed >= rdata.period);
  assign scan_end = ((CW'(idx) + CW'(1)) == task_count);
  assign advance = !(due && have && !push_ok);
  assign push_beat = res;

  // memory accesses and result push
  always_comb begin
    mem_cmd = '0;
    push = 1'b0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          case (req.command)
            tds_pkg::CMD_ADD: begin
              if (!full) begin
                mem_cmd.wr_en = 1'b1;
                mem_cmd.wr_addr = tds_pkg::ID_W'(task_count);
                mem_cmd.wdata.period = req.period_len;
                mem_cmd.wdata.last_run = '0;
                mem_cmd.wdata.run_total = '0;
                mem_cmd.wdata.en = 1'b1;
              end
            end
            tds_pkg::CMD_ENABLE, tds_pkg::CMD_DISABLE, tds_pkg::CMD_QUERY: begin
              mem_cmd.rd_en = in_range;
              mem_cmd.rd_addr = req.task_id;
            end
            tds_pkg::CMD_TICK: begin
              mem_cmd.rd_en = (task_count != '0);
              mem_cmd.rd_addr = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_RMW: begin
        mem_cmd.wr_en = 1'b1;
        mem_cmd.wr_addr = req_q.task_id;
        mem_cmd.wdata = rdata;
        mem_cmd.wdata.en = (req_q.command == tds_pkg::CMD_ENABLE);
      end
      S_SCAN: begin
        if (advance) begin
          if (due) begin
            mem_cmd.wr_en = 1'b1;
            mem_cmd.wr_addr = tds_pkg::ID_W'(idx);
            mem_cmd.wdata = rdata;
            mem_cmd.wdata.last_run = req_q.now_ms;
            mem_cmd.wdata.run_total = rdata.run_total + 1'b1;
          end
          push = due && have;
          if (!scan_end) begin
            mem_cmd.rd_en = 1'b1;
            mem_cmd.rd_addr = tds_pkg::ID_W'(AW'(idx + 1'b1));
          end
        end
      end
      S_RESP: begin
        push = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // sequencer state and registered results
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      task_count <= '0;
      have <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            req_q <= req;
            case (req.command)
              tds_pkg::CMD_CLEAR: begin
                task_count <= '0;
              end
              tds_pkg::CMD_ADD: begin
                if (full) begin
                  res <= make_beat(tds_pkg::ST_FULL, '0, '0, 1'b0, 1'b1);
                end else begin
                  res <= make_beat(tds_pkg::ST_ADDED, tds_pkg::ID_W'(task_count), '0, 1'b0,
                                   1'b1);
                  task_count <= task_count + 1'b1;
                end
                state <= S_RESP;
              end
              tds_pkg::CMD_ENABLE, tds_pkg::CMD_DISABLE: begin
                if (in_range) begin
                  state <= S_RMW;
                end
              end
              tds_pkg::CMD_TICK: begin
                if (task_count == '0) begin
                  res <= make_beat(tds_pkg::ST_NONE, '0, '0, 1'b0, 1'b1);
                  state <= S_RESP;
                end else begin
                  idx <= '0;
                  have <= 1'b0;
                  state <= S_SCAN;
                end
              end
              tds_pkg::CMD_QUERY: begin
                if (in_range) begin
                  state <= S_QRD;
                end else begin
                  res <= make_beat(tds_pkg::ST_STATS, req.task_id, '0, 1'b0, 1'b1);
                  state <= S_RESP;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_RMW: begin
          state <= S_IDLE;
        end
        S_QRD: begin
          res <= make_beat(tds_pkg::ST_STATS, req_q.task_id, rdata.run_total, rdata.en, 1'b1);
          state <= S_RESP;
        end
        S_SCAN: begin
          if (advance) begin
            if (scan_end) begin
              if (due) begin
                res <= make_beat(tds_pkg::ST_DUE, tds_pkg::ID_W'(idx), '0, 1'b0, 1'b1);
              end else if (have) begin
                res.last <= 1'b1;
              end else begin
                res <= make_beat(tds_pkg::ST_NONE, '0, '0, 1'b0, 1'b1);
              end
              have <= 1'b0;
              state <= S_RESP;
            end else begin
              if (due) begin
                res <= make_beat(tds_pkg::ST_DUE, tds_pkg::ID_W'(idx), '0, 1'b0, 1'b0);
                have <= 1'b1;
              end
              idx <= AW'(idx + 1'b1);
            end
          end
        end
        S_RESP: begin
          if (push_ok) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // task count never passes the table capacity
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    task_count <= CW'(CAP))
    else $error("task count beyond capacity");

  // the scan only writes entries inside the table
  a_scan_wr: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) && mem_cmd.wr_en |-> (tds_pkg::IDC_W'(mem_cmd.wr_addr)
      < tds_pkg::IDC_W'(task_count)))
    else $error("scan write outside table");

  // results pushed mid-scan are due results that never close the command
  a_scan_push: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) && push |-> push_ok && (push_beat.status == tds_pkg::ST_DUE)
      && !push_beat.last)
    else $error("bad mid-scan result");

  // the final beat of every command carries last
  a_resp_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP) |-> res.last)
    else $error("closing result without last");

  // clear empties the table
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) && req_valid && (req.command == tds_pkg::CMD_CLEAR)
      |=> task_count == '0)
    else $error("clear did not empty table");

endmodule

`default_nettype wire
